### rtl/tlv_fx_pkg.sv
package tlv_fx_pkg;

   localparam int unsigned MAX_MESSAGE_BYTES_DEF = 2048;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned OFFSET_W  = 11;
   localparam int unsigned CODE_W    = 16;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] RESULT_TAG   = 8'h02;
   localparam logic [LEN_W-1:0]  RESULT_MIN_LEN = 16'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_WANTED_TAG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MODE = 2'd1;

   localparam logic [MODE_W-1:0] LM_ANY  = 2'd0;
   localparam logic [MODE_W-1:0] LM_ONE  = 2'd1;
   localparam logic [MODE_W-1:0] LM_FOUR = 2'd2;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_VALUE
   } phase_type;

endpackage

### rtl/tlv_field_extractor_unit.sv
// Type-length-value record walker.
// Message bytes enter on the req_ channel, one word per byte, with
// req_last_byte marking the final byte of a message. Records are a tag byte,
// a 16-bit little-endian length and the value bytes. When the last byte of a
// message has been parsed, one summary word appears on the rsp_ channel and
// the parser returns to the start-of-message state; configuration is kept.
// Config (wanted tag, length mode) goes on the always-ready csr_ channel;
// the user must write it only while no message is in flight; not enforced.
// A byte is taken every cycle unless a last byte is held back as below: one
// input register feeds the parser, whose record state and summary register
// update when that byte is parsed, so each summary passes both registers.
// When the receiver stalls, the summary waits in the output register; bytes
// of the next message keep flowing in, and only a further last byte waits
// in the input register until the pending summary has been taken.
// Synchronous reset clears the parser, the summary valid flag and both
// configuration registers to zero.
module tlv_field_extractor_unit #(
   parameter int unsigned MAX_MESSAGE_BYTES = tlv_fx_pkg::MAX_MESSAGE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tlv_fx_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [tlv_fx_pkg::VALUE_W-1:0]      rsp_field_value,
   output logic [tlv_fx_pkg::OFFSET_W-1:0]     rsp_hit_offset,
   output logic [tlv_fx_pkg::LEN_W-1:0]        rsp_hit_length,
   output logic                                rsp_result_seen,
   output logic [tlv_fx_pkg::CODE_W-1:0]       rsp_result_code,
   output logic [tlv_fx_pkg::CODE_W-1:0]       rsp_error_code,
   output logic                                rsp_truncated,
   output logic                                rsp_overlong,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlv_fx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tlv_fx_pkg::BYTE_W-1:0]       csr_wdata
);
   import tlv_fx_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

   // Configuration
   logic [BYTE_W-1:0] wanted_tag_ff;
   logic [MODE_W-1:0] length_mode_ff;

   // Input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              fire;

   // Parser state
   phase_type          phase_ff, phase_in, phase_next;
   logic [BYTE_W-1:0]  tag_ff, tag_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] pend_ff, pend_in;
   logic               m_found_ff, m_found_in;
   logic [VALUE_W-1:0] m_value_ff, m_value_in;
   logic [OFFSET_W-1:0] m_offset_ff, m_offset_in;
   logic [LEN_W-1:0]   m_length_ff, m_length_in;
   logic               r_seen_ff, r_seen_in;
   logic [CODE_W-1:0]  r_code_ff, r_code_in;
   logic [CODE_W-1:0]  e_code_ff, e_code_in;
   logic               over_ff, over_in;

   // Working values for the byte in the input register
   logic               beyond_max;
   logic [LEN_W-1:0]   len_cur;
   logic [VALUE_W-1:0] pend_cur;
   logic [LEN_W-1:0]   value_idx;
   logic               commit;
   logic               len_ok;
   logic [31:0]        offset_calc;

   // Output register
   logic                rsp_valid_ff;
   logic                o_found_ff;
   logic [VALUE_W-1:0]  o_value_ff;
   logic [OFFSET_W-1:0] o_offset_ff;
   logic [LEN_W-1:0]    o_length_ff;
   logic                o_seen_ff;
   logic [CODE_W-1:0]   o_rcode_ff;
   logic [CODE_W-1:0]   o_ecode_ff;
   logic                o_trunc_ff;
   logic                o_over_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_tag_ff  <= '0;
         length_mode_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WANTED_TAG:  wanted_tag_ff  <= csr_wdata;
            CSR_LENGTH_MODE: length_mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // A last byte may only be parsed when the summary register is empty or being taken.
   assign fire      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   assign beyond_max = pos_ff >= POS_MAX;

   // Next parse phase
   always_comb begin
      phase_next = phase_ff;
      if (!beyond_max) begin
         case (phase_ff)
            PH_TAG:    phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = commit ? PH_TAG : PH_VALUE;
            PH_VALUE:  phase_next = commit ? PH_TAG : PH_VALUE;
            default:   phase_next = PH_TAG;
         endcase
      end
   end

   always_comb begin
      case (length_mode_ff)
         LM_ANY:  len_ok = 1'b1;
         LM_ONE:  len_ok = len_cur == LEN_W'(1);
         LM_FOUR: len_ok = len_cur == LEN_W'(4);
         default: len_ok = 1'b0;
      endcase
   end

   // Datapath for the byte being parsed
   always_comb begin
      len_cur   = (phase_ff == PH_LEN_HI) ? {in_byte_ff, len_ff[7:0]} : len_ff;
      value_idx = len_ff - left_ff;
      pend_cur  = pend_ff;
      if (phase_ff == PH_VALUE && value_idx < LEN_W'(4)) begin
         pend_cur[8*value_idx[1:0] +: 8] = in_byte_ff;
      end
      commit = !beyond_max &&
               ((phase_ff == PH_LEN_HI && len_cur == '0) ||
                (phase_ff == PH_VALUE && left_ff == LEN_W'(1)));
      offset_calc = 32'(pos_ff) + 32'd1 - 32'(len_cur);

      tag_in      = tag_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      over_in     = over_ff || beyond_max;
      m_found_in  = m_found_ff;
      m_value_in  = m_value_ff;
      m_offset_in = m_offset_ff;
      m_length_in = m_length_ff;
      r_seen_in   = r_seen_ff;
      r_code_in   = r_code_ff;
      e_code_in   = e_code_ff;

      if (!beyond_max) begin
         pos_in = pos_ff + POS_W'(1);
         case (phase_ff)
            PH_TAG: begin
               tag_in  = in_byte_ff;
               len_in  = '0;
               pend_in = '0;
            end
            PH_LEN_LO: len_in = LEN_W'(in_byte_ff);
            PH_LEN_HI: begin
               len_in  = len_cur;
               left_in = len_cur;
            end
            PH_VALUE: begin
               pend_in = pend_cur;
               left_in = left_ff - LEN_W'(1);
            end
            default: ;
         endcase
      end

      if (commit) begin
         if (tag_ff == RESULT_TAG && len_cur >= RESULT_MIN_LEN) begin
            r_seen_in = 1'b1;
            r_code_in = pend_cur[15:0];
            e_code_in = pend_cur[31:16];
         end
         if (tag_ff == wanted_tag_ff && len_ok) begin
            m_found_in  = 1'b1;
            m_value_in  = pend_cur;
            m_offset_in = offset_calc[OFFSET_W-1:0];
            m_length_in = len_cur;
         end
      end
   end

   // Parser registers; the end of a message returns them to the reset state.
   always_ff @(posedge clock) begin
      if (reset || (fire && in_last_ff)) begin
         phase_ff    <= PH_TAG;
         tag_ff      <= '0;
         len_ff      <= '0;
         left_ff     <= '0;
         pos_ff      <= '0;
         pend_ff     <= '0;
         m_found_ff  <= 1'b0;
         m_value_ff  <= '0;
         m_offset_ff <= '0;
         m_length_ff <= '0;
         r_seen_ff   <= 1'b0;
         r_code_ff   <= '0;
         e_code_ff   <= '0;
         over_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         pend_ff     <= pend_in;
         m_found_ff  <= m_found_in;
         m_value_ff  <= m_value_in;
         m_offset_ff <= m_offset_in;
         m_length_ff <= m_length_in;
         r_seen_ff   <= r_seen_in;
         r_code_ff   <= r_code_in;
         e_code_ff   <= e_code_in;
         over_ff     <= over_in;
      end
   end

   assign phase_in = phase_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         o_found_ff  <= m_found_in;
         o_value_ff  <= m_value_in;
         o_offset_ff <= m_offset_in;
         o_length_ff <= m_length_in;
         o_seen_ff   <= r_seen_in;
         o_rcode_ff  <= r_code_in;
         o_ecode_ff  <= e_code_in;
         o_trunc_ff  <= phase_next != PH_TAG;
         o_over_ff   <= over_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = o_found_ff;
   assign rsp_field_value = o_value_ff;
   assign rsp_hit_offset  = o_offset_ff;
   assign rsp_hit_length  = o_length_ff;
   assign rsp_result_seen = o_seen_ff;
   assign rsp_result_code = o_rcode_ff;
   assign rsp_error_code  = o_ecode_ff;
   assign rsp_truncated   = o_trunc_ff;
   assign rsp_overlong    = o_over_ff;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("summary valid straight after reset");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_field_value == '0 && rsp_hit_length == '0 && rsp_hit_offset == '0))
      else $error("match fields set without a match");

   a_no_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_seen) |->
         (rsp_result_code == '0 && rsp_error_code == '0))
      else $error("result codes set without a result record");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while a last byte is blocked");

endmodule
